// ===== hdl/i2c_mw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// i2c_mw_pkg
// Shared types and constants of the write-only I2C master engine.
// ============================================================================
package i2c_mw_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned DELAY_W       = 16;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned BITCNT_W      = 4;

    // Ticks per bus phase after reset.
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd16;

    // Depth of the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Bus sequencer, one-hot.
    typedef enum logic [10:0] {
        PH_IDLE    = 11'b000_0000_0001,
        PH_START_A = 11'b000_0000_0010,
        PH_START_B = 11'b000_0000_0100,
        PH_BIT_LO  = 11'b000_0000_1000,
        PH_BIT_HI  = 11'b000_0001_0000,
        PH_ACK_LO  = 11'b000_0010_0000,
        PH_ACK_HI  = 11'b000_0100_0000,
        PH_WAIT    = 11'b000_1000_0000,
        PH_STOP_A  = 11'b001_0000_0000,
        PH_STOP_B  = 11'b010_0000_0000,
        PH_STOP_C  = 11'b100_0000_0000
    } t_phase;

    // One classified input beat.
    typedef struct packed {
        logic              is_load;
        logic [BYTE_W-1:0] byte_value;
        logic              first_byte;
        logic              last_byte;
        logic              sda_in;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic scl_drive_low;
        logic sda_drive_low;
        logic ready_for_byte;
        logic load_rejected;
        logic byte_done;
        logic ack_seen;
        logic transaction_done;
        logic transaction_ok;
    } t_result;

endpackage : i2c_mw_pkg
`default_nettype wire

// ===== hdl/i2c_mw_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// i2c_mw_if
// Valid/ready channels of the I2C master engine: input items, results and
// the delay register write port.
// ============================================================================
interface i2c_mw_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
    logic       sda_in;

    modport source (output valid, action, byte_value, first_byte, last_byte, sda_in,
                    input ready);
    modport sink   (input valid, action, byte_value, first_byte, last_byte, sda_in,
                    output ready);
endinterface : i2c_mw_in_if

interface i2c_mw_out_if;
    logic valid;
    logic ready;
    logic scl_drive_low;
    logic sda_drive_low;
    logic ready_for_byte;
    logic load_rejected;
    logic byte_done;
    logic ack_seen;
    logic transaction_done;
    logic transaction_ok;

    modport source (output valid, scl_drive_low, sda_drive_low, ready_for_byte,
                    load_rejected, byte_done, ack_seen, transaction_done,
                    transaction_ok, input ready);
    modport sink   (input valid, scl_drive_low, sda_drive_low, ready_for_byte,
                    load_rejected, byte_done, ack_seen, transaction_done,
                    transaction_ok, output ready);
endinterface : i2c_mw_out_if

interface i2c_mw_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] delay_count;

    modport source (output valid, delay_count, input ready);
    modport sink   (input valid, delay_count, output ready);
endinterface : i2c_mw_cfg_if
`default_nettype wire

// ===== hdl/i2c_mw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// i2c_mw_front
// Takes input beats, classifies them as tick or byte load and registers them.
// ============================================================================
module i2c_mw_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    i2c_mw_in_if.sink         i_in,
    output logic              o_valid,
    output i2c_mw_pkg::t_cmd  o_cmd,
    input  wire logic         i_ready
);
    import i2c_mw_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    logic take;

    assign i_in.ready = !r_valid || i_ready;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.is_load    <= i_in.action;
            r_cmd.byte_value <= i_in.byte_value;
            r_cmd.first_byte <= i_in.first_byte;
            r_cmd.last_byte  <= i_in.last_byte;
            r_cmd.sda_in     <= i_in.sda_in;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule : i2c_mw_front
`default_nettype wire

// ===== hdl/i2c_mw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// i2c_mw_queue
// Short register queue of classified beats between the front and the back.
// ============================================================================
module i2c_mw_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire i2c_mw_pkg::t_cmd   i_cmd,
    output logic                    o_ready,
    output logic                    o_valid,
    output i2c_mw_pkg::t_cmd        o_cmd,
    input  wire logic               i_ready
);
    import i2c_mw_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule : i2c_mw_queue
`default_nettype wire

// ===== hdl/i2c_mw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// i2c_mw_back
// Bus sequencer: holding register, phase timer, bit shifter and the result
// register. Carries out one queued beat per cycle while the result is not stalled.
// ============================================================================
module i2c_mw_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire i2c_mw_pkg::t_cmd           i_cmd,
    output logic                            o_ready,
    input  wire logic                       i_cfg_valid,
    input  wire logic [15:0]                i_cfg_delay,
    output logic                            o_res_valid,
    output i2c_mw_pkg::t_result             o_res,
    input  wire logic                       i_res_ready
);
    import i2c_mw_pkg::*;

    logic [DELAY_W-1:0]  r_delay;
    t_phase              r_phase,        n_phase;
    logic [BITCNT_W-1:0] r_bit_count,    n_bit_count;
    logic [BYTE_W-1:0]   r_shift,        n_shift;
    logic [DELAY_W-1:0]  r_tick,         n_tick;
    logic [BYTE_W-1:0]   r_held_byte,    n_held_byte;
    logic                r_held_valid,   n_held_valid;
    logic                r_held_first,   n_held_first;
    logic                r_held_last,    n_held_last;
    logic                r_current_last, n_current_last;
    logic                r_all_acked,    n_all_acked;
    logic                r_res_valid;
    t_result             r_res,          n_res;

    logic                take;
    logic [DELAY_W-1:0]  limit;
    logic [DELAY_W-1:0]  tick_inc;
    logic                elapsed;
    logic [DELAY_W-1:0]  tick_after;
    logic [BITCNT_W-1:0] bit_inc;

    assign o_ready = !r_res_valid || i_res_ready;
    assign take    = i_valid && o_ready;

    // Phase timer: a delay of zero behaves as one tick.
    assign limit      = (r_delay == '0) ? DELAY_W'(1) : r_delay;
    assign tick_inc   = r_tick + 1'b1;
    assign elapsed    = (tick_inc >= limit);
    assign tick_after = elapsed ? '0 : tick_inc;
    assign bit_inc    = r_bit_count + 1'b1;

    always_comb begin
        n_phase        = r_phase;
        n_bit_count    = r_bit_count;
        n_shift        = r_shift;
        n_tick         = r_tick;
        n_held_byte    = r_held_byte;
        n_held_valid   = r_held_valid;
        n_held_first   = r_held_first;
        n_held_last    = r_held_last;
        n_current_last = r_current_last;
        n_all_acked    = r_all_acked;
        n_res          = '0;

        if (i_cmd.is_load) begin
            if (r_held_valid) begin
                n_res.load_rejected = 1'b1;
            end else begin
                n_held_byte  = i_cmd.byte_value;
                n_held_first = i_cmd.first_byte;
                n_held_last  = i_cmd.last_byte;
                n_held_valid = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (r_held_valid) begin
                        n_held_valid = 1'b0;
                        // An address byte opens a transaction; anything else is dropped.
                        if (r_held_first) begin
                            n_shift        = {r_held_byte[BYTE_W-2:0], 1'b0};
                            n_current_last = r_held_last;
                            n_bit_count    = '0;
                            n_all_acked    = 1'b1;
                            n_tick         = '0;
                            n_phase        = PH_START_A;
                        end
                    end
                end
                PH_START_A: begin
                    n_tick = tick_after;
                    if (elapsed) begin
                        n_phase = PH_START_B;
                    end
                end
                PH_START_B: begin
                    n_tick = tick_after;
                    if (elapsed) begin
                        n_phase = PH_BIT_LO;
                    end
                end
                PH_BIT_LO: begin
                    n_tick = tick_after;
                    if (elapsed) begin
                        n_phase = PH_BIT_HI;
                    end
                end
                PH_BIT_HI: begin
                    n_tick = tick_after;
                    if (elapsed) begin
                        n_shift     = {r_shift[BYTE_W-2:0], 1'b0};
                        n_bit_count = bit_inc;
                        n_phase     = (bit_inc >= BITCNT_W'(BITS_PER_BYTE)) ? PH_ACK_LO
                                                                            : PH_BIT_LO;
                    end
                end
                PH_ACK_LO: begin
                    n_tick = tick_after;
                    if (elapsed) begin
                        n_phase = PH_ACK_HI;
                    end
                end
                PH_ACK_HI: begin
                    n_tick = tick_after;
                    if (elapsed) begin
                        n_res.byte_done = 1'b1;
                        n_res.ack_seen  = !i_cmd.sda_in;
                        if (i_cmd.sda_in) begin
                            n_all_acked = 1'b0;
                            n_phase     = PH_STOP_A;
                        end else if (r_current_last) begin
                            n_phase = PH_STOP_A;
                        end else if (r_held_valid) begin
                            n_shift        = r_held_byte;
                            n_current_last = r_held_last;
                            n_held_valid   = 1'b0;
                            n_bit_count    = '0;
                            n_phase        = PH_BIT_LO;
                        end else begin
                            n_phase = PH_WAIT;
                        end
                    end
                end
                PH_WAIT: begin
                    if (r_held_valid) begin
                        n_shift        = r_held_byte;
                        n_current_last = r_held_last;
                        n_held_valid   = 1'b0;
                        n_bit_count    = '0;
                        n_tick         = '0;
                        n_phase        = PH_BIT_LO;
                    end
                end
                PH_STOP_A: begin
                    n_tick = tick_after;
                    if (elapsed) begin
                        n_phase = PH_STOP_B;
                    end
                end
                PH_STOP_B: begin
                    n_tick = tick_after;
                    if (elapsed) begin
                        n_phase = PH_STOP_C;
                    end
                end
                PH_STOP_C: begin
                    n_tick = tick_after;
                    if (elapsed) begin
                        n_res.transaction_done = 1'b1;
                        n_res.transaction_ok   = r_all_acked;
                        n_all_acked            = 1'b1;
                        n_phase                = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            endcase
        end

        // Line drives follow the phase after this beat.
        case (n_phase)
            PH_START_B: begin
                n_res.sda_drive_low = 1'b1;
            end
            PH_BIT_LO: begin
                n_res.scl_drive_low = 1'b1;
                n_res.sda_drive_low = !n_shift[BYTE_W-1];
            end
            PH_BIT_HI: begin
                n_res.sda_drive_low = !n_shift[BYTE_W-1];
            end
            PH_ACK_LO, PH_WAIT: begin
                n_res.scl_drive_low = 1'b1;
            end
            PH_STOP_A: begin
                n_res.scl_drive_low = 1'b1;
                n_res.sda_drive_low = 1'b1;
            end
            PH_STOP_B: begin
                n_res.sda_drive_low = 1'b1;
            end
            default: begin
                n_res.scl_drive_low = 1'b0;
            end
        endcase
        n_res.ready_for_byte = !n_held_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay        <= DELAY_RESET;
            r_phase        <= PH_IDLE;
            r_bit_count    <= '0;
            r_shift        <= '0;
            r_tick         <= '0;
            r_held_valid   <= 1'b0;
            r_held_first   <= 1'b0;
            r_held_last    <= 1'b0;
            r_current_last <= 1'b0;
            r_all_acked    <= 1'b1;
            r_res_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_delay <= i_cfg_delay;
            end
            if (take) begin
                r_phase        <= n_phase;
                r_bit_count    <= n_bit_count;
                r_shift        <= n_shift;
                r_tick         <= n_tick;
                r_held_valid   <= n_held_valid;
                r_held_first   <= n_held_first;
                r_held_last    <= n_held_last;
                r_current_last <= n_current_last;
                r_all_acked    <= n_all_acked;
                r_res_valid    <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_held_byte <= n_held_byte;
            r_res       <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule : i2c_mw_back
`default_nettype wire

// ===== hdl/i2c_master_write_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// i2c_master_write_engine
// Write-only open-drain I2C master: START, address, data bytes, ACK checks
// and STOP, driven by tick and byte-load beats.
// ============================================================================
//
//  Channel  | Direction | Beat carries
//  ---------+-----------+------------------------------------------------------
//  i_in     | in        | action, byte_value, first_byte, last_byte, sda_in
//  o_res    | out       | line drives, holding status, ACK and STOP reports
//  i_cfg    | in        | delay_count (ticks per bus phase), always ready
//
// Every input beat yields exactly one result beat. The block takes one beat
// per cycle while o_res is not stalled; a beat is registered in the front
// register, then written into the queue, and its result is then registered
// in the output register by the sequencer. The sequencer handles one beat
// each cycle while o_res is not stalled, so its state update is the one loop
// that sets the rate. A stall on o_res fills the two-entry queue and then the
// front register before i_in.ready drops. Reset is synchronous and active
// low; afterwards the bus is idle and delay_count is 16.
// ============================================================================
module i2c_master_write_engine (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    i2c_mw_in_if.sink    i_in,
    i2c_mw_out_if.source o_res,
    i2c_mw_cfg_if.sink   i_cfg
);
    import i2c_mw_pkg::*;

    // Front to queue.
    logic    front_valid;
    t_cmd    front_cmd;
    logic    queue_ready;

    // Queue to sequencer.
    logic    queue_valid;
    t_cmd    queue_cmd;
    logic    back_ready;

    // Sequencer result.
    logic    res_valid;
    t_result res;

    // Write the delay register only while the bus is idle; no check enforces it.
    assign i_cfg.ready = 1'b1;

    i2c_mw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (front_valid),
        .o_cmd   (front_cmd),
        .i_ready (queue_ready)
    );

    i2c_mw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_cmd   (front_cmd),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_ready (back_ready)
    );

    i2c_mw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_cmd       (queue_cmd),
        .o_ready     (back_ready),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_delay (i_cfg.delay_count),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_res.ready)
    );

    // Result beat onto the output channel.
    assign o_res.valid            = res_valid;
    assign o_res.scl_drive_low    = res.scl_drive_low;
    assign o_res.sda_drive_low    = res.sda_drive_low;
    assign o_res.ready_for_byte   = res.ready_for_byte;
    assign o_res.load_rejected    = res.load_rejected;
    assign o_res.byte_done        = res.byte_done;
    assign o_res.ack_seen         = res.ack_seen;
    assign o_res.transaction_done = res.transaction_done;
    assign o_res.transaction_ok   = res.transaction_ok;

endmodule : i2c_master_write_engine
`default_nettype wire
